// File: hdl/sorted_priority_queue_unit_defines.svh
// assertion macros shared by the sorted priority queue rtl
`ifndef SORTED_PRIORITY_QUEUE_UNIT_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_UNIT_DEFINES_SVH

// same-cycle implication, checked on clock, off while reset is high
`define SPQ_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked on clock, off while reset is high
`define SPQ_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/spq_pkg.sv
// package with the types and constants of the sorted priority queue
`timescale 1ns / 1ps

package spq_pkg;

   localparam int DEPTH     = 16;
   localparam int TAG_BITS  = 16;
   localparam int PRIO_BITS = 16;
   localparam int CNT_BITS  = $clog2(DEPTH + 1);

   typedef enum logic [1:0] {
      CMD_ENQUEUE = 2'd0,
      CMD_DEQUEUE = 2'd1,
      CMD_CHANGE  = 2'd2,
      CMD_CLEAR   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_EMPTY    = 2'd1,
      ST_FULL     = 2'd2,
      ST_NOTFOUND = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_REMOVE,
      CELL_SHIFT
   } cell_op_type;

   typedef struct packed {
      logic [TAG_BITS-1:0]  tag;
      logic [PRIO_BITS-1:0] prio;
   } entry_type;

   typedef struct packed {
      cell_op_type          op;
      logic [TAG_BITS-1:0]  tag;
      logic [PRIO_BITS-1:0] prio;
   } cell_ctrl_type;

endpackage

// File: hdl/spq_if.sv
// request and response channel interfaces of the sorted priority queue
`timescale 1ns / 1ps

interface spq_req_if;
   import spq_pkg::*;

   logic                        valid;
   logic                        ready;
   cmd_type                     cmd;
   logic [TAG_BITS-1:0]         tag;
   logic signed [PRIO_BITS-1:0] prio;

   modport source (output valid, output cmd, output tag, output prio, input ready);
   modport sink   (input valid, input cmd, input tag, input prio, output ready);
endinterface

interface spq_rsp_if;
   import spq_pkg::*;

   logic                        valid;
   logic                        ready;
   logic [TAG_BITS-1:0]         out_tag;
   logic signed [PRIO_BITS-1:0] out_prio;
   logic [CNT_BITS-1:0]         fill;
   status_type                  status;

   modport source (output valid, output out_tag, output out_prio, output fill,
                   output status, input ready);
   modport sink   (input valid, input out_tag, input out_prio, input fill,
                   input status, output ready);
endinterface

// File: hdl/sorted_priority_queue_unit.sv
// Sorted priority queue built as a chain of entry cells.
// Usage:
//   req_if carries one command per beat: cmd (enqueue, dequeue, change
//   priority, clear), tag and prio. rsp_if returns exactly one beat per
//   command: out_tag/out_prio (the removed entry on a good dequeue, else the
//   head after the command, zero when empty), fill and status.
// Timing:
//   enqueue, dequeue and clear update the count and the chain at the
//   accepting edge; the response register loads in S_REPORT once it is free.
//   change priority of a held tag makes two passes of the chain: one pass
//   removes the first entry with the tag, a second pass (S_INSERT) inserts
//   it with the new priority; an absent tag goes straight to S_REPORT. Every
//   cell compares against the broadcast key and moves one entry to or from
//   a neighbor in the same pass, so the chain length does not add passes.
// Reset:
//   synchronous, active high; the queue comes out empty and no response is
//   pending. Entry storage itself is not cleared.
// Backpressure:
//   the response waits in its output register while rsp_if.ready is low;
//   one more command is taken meanwhile and held until the register frees.
`timescale 1ns / 1ps
`include "sorted_priority_queue_unit_defines.svh"

module sorted_priority_queue_unit (
   input  logic      clock,
   input  logic      reset,
   spq_req_if.sink   req_if,
   spq_rsp_if.source rsp_if
);
   import spq_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_INSERT,
      S_REPORT
   } state_type;

   state_type                   state_ff;
   state_type                   state_in;
   logic [CNT_BITS-1:0]         count_ff;
   logic [CNT_BITS-1:0]         count_in;
   logic [TAG_BITS-1:0]         tag_ff;
   logic [PRIO_BITS-1:0]        prio_ff;
   status_type                  status_ff;
   status_type                  status_in;
   logic                        have_ff;
   logic                        have_in;
   entry_type                   dq_ff;
   logic                        rsp_valid_ff;
   logic [TAG_BITS-1:0]         out_tag_ff;
   logic [PRIO_BITS-1:0]        out_prio_ff;
   logic [CNT_BITS-1:0]         fill_ff;
   status_type                  out_status_ff;

   cell_ctrl_type               cell_ctrl;
   entry_type                   cell_entry  [DEPTH];
   logic                        cell_before [DEPTH];
   logic                        cell_found  [DEPTH];
   logic                        cell_occ    [DEPTH];

   logic                        accept;
   logic                        full;
   logic                        empty;
   logic                        rsp_free;

   assign req_if.ready = (state_ff == S_IDLE) && !reset;
   assign accept       = req_if.valid && req_if.ready;
   assign full         = count_ff == CNT_BITS'(DEPTH);
   assign empty        = count_ff == '0;
   assign rsp_free     = !rsp_valid_ff || rsp_if.ready;

   // the chain of cells, each told by the count whether it holds an entry
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      entry_type left_entry;
      logic      left_before;
      entry_type right_entry;
      logic      found_in;

      assign cell_occ[i] = CNT_BITS'(i) < count_ff;

      if (i == 0) begin : g_head
         assign left_entry  = '0;
         assign left_before = 1'b1;
         assign found_in    = 1'b0;
      end else begin : g_body
         assign left_entry  = cell_entry[i-1];
         assign left_before = cell_before[i-1];
         assign found_in    = cell_found[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign right_entry = cell_entry[i];
      end else begin : g_inner
         assign right_entry = cell_entry[i+1];
      end

      spq_cell u_cell (
         .clock       (clock),
         .ctrl        (cell_ctrl),
         .occupied    (cell_occ[i]),
         .left_entry  (left_entry),
         .left_before (left_before),
         .right_entry (right_entry),
         .found_in    (found_in),
         .entry       (cell_entry[i]),
         .ahead       (cell_before[i]),
         .found_out   (cell_found[i])
      );
   end

   // command decode: what the chain does this cycle and how the count moves
   always_comb begin
      cell_ctrl.op   = CELL_HOLD;
      cell_ctrl.tag  = req_if.tag;
      cell_ctrl.prio = req_if.prio;
      count_in       = count_ff;
      state_in       = state_ff;
      status_in      = status_ff;
      have_in        = have_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in  = S_REPORT;
               status_in = ST_OK;
               have_in   = 1'b0;
               case (req_if.cmd)
                  CMD_ENQUEUE: begin
                     if (full) begin
                        status_in = ST_FULL;
                     end else begin
                        cell_ctrl.op = CELL_INSERT;
                        count_in     = count_ff + 1'b1;
                     end
                  end
                  CMD_DEQUEUE: begin
                     if (empty) begin
                        status_in = ST_EMPTY;
                     end else begin
                        cell_ctrl.op = CELL_SHIFT;
                        have_in      = 1'b1;
                        count_in     = count_ff - 1'b1;
                     end
                  end
                  CMD_CHANGE: begin
                     // last cell's found flag covers the whole chain
                     if (!cell_found[DEPTH-1]) begin
                        status_in = ST_NOTFOUND;
                     end else begin
                        cell_ctrl.op = CELL_REMOVE;
                        count_in     = count_ff - 1'b1;
                        state_in     = S_INSERT;
                     end
                  end
                  default: begin
                     count_in = '0;
                  end
               endcase
            end
         end
         S_INSERT: begin
            // second pass of change priority, key from the held beat
            cell_ctrl.op   = CELL_INSERT;
            cell_ctrl.tag  = tag_ff;
            cell_ctrl.prio = prio_ff;
            count_in       = count_ff + 1'b1;
            state_in       = S_REPORT;
         end
         S_REPORT: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (state_ff == S_REPORT && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // held beat, removed head and the response payload
   always_ff @(posedge clock) begin
      status_ff <= status_in;
      have_ff   <= have_in;
      if (accept) begin
         tag_ff  <= req_if.tag;
         prio_ff <= req_if.prio;
         dq_ff   <= cell_entry[0];
      end
      if (state_ff == S_REPORT && rsp_free) begin
         fill_ff       <= count_ff;
         out_status_ff <= status_ff;
         if (have_ff) begin
            out_tag_ff  <= dq_ff.tag;
            out_prio_ff <= dq_ff.prio;
         end else if (!empty) begin
            out_tag_ff  <= cell_entry[0].tag;
            out_prio_ff <= cell_entry[0].prio;
         end else begin
            out_tag_ff  <= '0;
            out_prio_ff <= '0;
         end
      end
   end

   assign rsp_if.valid    = rsp_valid_ff;
   assign rsp_if.out_tag  = out_tag_ff;
   assign rsp_if.out_prio = out_prio_ff;
   assign rsp_if.fill     = fill_ff;
   assign rsp_if.status   = out_status_ff;

   `SPQ_ASSERT_NXT(a_accept_busy, accept, state_ff != S_IDLE, "accepted beat left queue idle")
   `SPQ_ASSERT_IMP(a_full_fill, rsp_valid_ff && out_status_ff == ST_FULL,
                   fill_ff == CNT_BITS'(DEPTH), "full status with room left")
   `SPQ_ASSERT_IMP(a_empty_zero, rsp_valid_ff && out_status_ff == ST_EMPTY,
                   fill_ff == '0 && out_tag_ff == '0 && out_prio_ff == '0,
                   "empty status with data")
   `SPQ_ASSERT_IMP(a_insert_room, state_ff == S_INSERT, count_ff < CNT_BITS'(DEPTH),
                   "reinsert without a free slot")
   `SPQ_ASSERT_NXT(a_dequeue_count, accept && req_if.cmd == CMD_DEQUEUE && !empty,
                   count_ff == $past(count_ff) - 1'b1, "dequeue did not drop the count")

endmodule

// File: hdl/spq_cell.sv
// one slot of the sorted chain: holds an entry and trades with its neighbors
`timescale 1ns / 1ps

module spq_cell (
   input  logic                  clock,
   input  spq_pkg::cell_ctrl_type ctrl,
   input  logic                  occupied,
   input  spq_pkg::entry_type    left_entry,
   input  logic                  left_before,
   input  spq_pkg::entry_type    right_entry,
   input  logic                  found_in,
   output spq_pkg::entry_type    entry,
   output logic                  ahead,
   output logic                  found_out
);
   import spq_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;
   entry_type new_entry;
   logic      prio_less;
   logic      prio_equal;
   logic      match;

   assign new_entry.tag  = ctrl.tag;
   assign new_entry.prio = ctrl.prio;

   // strict key order: smaller priority first, then smaller tag
   assign prio_less  = $signed(entry_ff.prio) < $signed(ctrl.prio);
   assign prio_equal = entry_ff.prio == ctrl.prio;
   assign ahead      = occupied && (prio_less || (prio_equal && entry_ff.tag < ctrl.tag));

   assign match     = occupied && (entry_ff.tag == ctrl.tag);
   assign found_out = found_in || match;

   always_comb begin
      case (ctrl.op)
         CELL_INSERT: begin
            if (ahead) begin
               entry_in = entry_ff;
            end else if (left_before) begin
               entry_in = new_entry;
            end else begin
               entry_in = left_entry;
            end
         end
         CELL_REMOVE: entry_in = found_out ? right_entry : entry_ff;
         CELL_SHIFT:  entry_in = right_entry;
         default:     entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule
